>>> rtl/core/lbfv_pkg.sv
// lbfv_pkg: shared types and chain lengths for the lorentz boost block
// no dependencies; used by every module in rtl/core
`default_nettype none

package lbfv_pkg;

  localparam int NORM_CELLS = 5;
  localparam int ROOT_CELLS = 31;
  localparam int QUO1_CELLS = 61;
  localparam int QUO2_CELLS = 30;

  // working word handed from cell to cell
  typedef struct packed {
    logic signed [31:0] e;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [63:0] bp;
    logic               invalid;
    logic               zero;
    logic [4:0]         k;
    logic [60:0]        rad;
    logic [61:0]        root;
    logic [62:0]        rem;
    logic [61:0]        dvs;
    logic [60:0]        quo;
    logic [60:0]        gq;
  } lbfv_word_t;

  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic               beta_invalid;
    logic               overflow;
  } lbfv_res_t;

endpackage

`default_nettype wire

>>> rtl/core/lbfv_ifs.sv
// lbfv_in_if, lbfv_out_if: valid/ready channels of the lorentz boost block
// no dependencies
`default_nettype none

interface lbfv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy_in;
  logic signed [31:0] mom_x_in;
  logic signed [31:0] mom_y_in;
  logic signed [31:0] mom_z_in;
  logic signed [31:0] beta_x;
  logic signed [31:0] beta_y;
  logic signed [31:0] beta_z;

  modport source (
    output valid, energy_in, mom_x_in, mom_y_in, mom_z_in, beta_x, beta_y, beta_z,
    input  ready
  );
  modport sink (
    input  valid, energy_in, mom_x_in, mom_y_in, mom_z_in, beta_x, beta_y, beta_z,
    output ready
  );
endinterface

interface lbfv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy_out;
  logic signed [31:0] mom_x_out;
  logic signed [31:0] mom_y_out;
  logic signed [31:0] mom_z_out;
  logic               beta_invalid;
  logic               overflow;

  modport source (
    output valid, energy_out, mom_x_out, mom_y_out, mom_z_out, beta_invalid, overflow,
    input  ready
  );
  modport sink (
    input  valid, energy_out, mom_x_out, mom_y_out, mom_z_out, beta_invalid, overflow,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/lbfv_norm_cell.sv
// lbfv_norm_cell: one step of the even-shift normalization of 1 - beta^2
// depends on lbfv_pkg
`default_nettype none

module lbfv_norm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [2:0]         step_i,
  input  logic               valid_i,
  input  lbfv_pkg::lbfv_word_t word_i,
  output logic               valid_o,
  output lbfv_pkg::lbfv_word_t word_o
);
  import lbfv_pkg::*;

  logic       valid_r;
  lbfv_word_t word_r;
  lbfv_word_t word_nxt;
  logic [4:0] span;
  logic [5:0] sh;
  logic       low_rad;

  always_comb begin
    span    = 5'd16 >> step_i;
    sh      = {span, 1'b0};
    low_rad = (word_i.rad >> (6'd60 - sh)) == '0;
    word_nxt = word_i;
    if (low_rad) begin
      word_nxt.rad = word_i.rad << sh;
      word_nxt.k   = word_i.k + span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

`default_nettype wire

>>> rtl/core/lbfv_root_cell.sv
// lbfv_root_cell: one digit of the integer square root of the normalized radicand
// depends on lbfv_pkg
`default_nettype none

module lbfv_root_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [4:0]         iter_i,
  input  logic               valid_i,
  input  lbfv_pkg::lbfv_word_t word_i,
  output logic               valid_o,
  output lbfv_pkg::lbfv_word_t word_o
);
  import lbfv_pkg::*;

  logic        valid_r;
  lbfv_word_t  word_r;
  lbfv_word_t  word_nxt;
  logic [61:0] bit_v;
  logic [61:0] trial;
  logic        fits;

  always_comb begin
    bit_v = 62'd1 << (6'd60 - {iter_i, 1'b0});
    trial = word_i.root + bit_v;
    fits  = {1'b0, word_i.rad} >= trial;
    word_nxt = word_i;
    if (fits) begin
      word_nxt.rad  = word_i.rad - trial[60:0];
      word_nxt.root = (word_i.root >> 1) + bit_v;
    end else begin
      word_nxt.root = word_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

`default_nettype wire

>>> rtl/core/lbfv_div_cell.sv
// lbfv_div_cell: one quotient bit of restoring division, shared by both dividers
// depends on lbfv_pkg
`default_nettype none

module lbfv_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  lbfv_pkg::lbfv_word_t word_i,
  output logic               valid_o,
  output lbfv_pkg::lbfv_word_t word_o
);
  import lbfv_pkg::*;

  logic        valid_r;
  lbfv_word_t  word_r;
  lbfv_word_t  word_nxt;
  logic        ge;
  logic [62:0] diff;

  always_comb begin
    ge   = word_i.rem >= {1'b0, word_i.dvs};
    diff = ge ? word_i.rem - {1'b0, word_i.dvs} : word_i.rem;
    word_nxt     = word_i;
    word_nxt.rem = diff << 1;
    word_nxt.quo = {word_i.quo[59:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

`default_nettype wire

>>> rtl/core/lbfv_tail.sv
// lbfv_tail: five-stage multiply/accumulate back end, saturation and flags
// depends on lbfv_pkg
`default_nettype none

module lbfv_tail (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  lbfv_pkg::lbfv_word_t word_i,
  output logic               valid_o,
  output lbfv_pkg::lbfv_res_t res_o
);
  import lbfv_pkg::*;

  typedef struct packed {
    logic [31:0]       e;
    logic [2:0][31:0]  p;
    logic [2:0][31:0]  b;
    logic              inv;
  } tl_carry_t;

  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    logic [32:0] r;
    if ((&v[71:31]) || !(|v[71:31])) begin
      r = {1'b0, v[31:0]};
    end else if (v[71]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7fff_ffff};
    end
    return r;
  endfunction

  logic [4:0] vld_r;
  tl_carry_t  c_r [4];
  tl_carry_t  c_nxt;

  // stage 0
  logic [60:0]        s0_hq_r, s0_hq_nxt;
  logic [60:0]        s0_gq_r;
  logic signed [65:0] s0_es_r, s0_es_nxt;

  // bp is split once it is registered in stage 0
  logic [31:0]        word_bp_lo_r;
  logic signed [31:0] word_bp_hi_r;

  // stage 1
  logic [63:0]        s1_hll_r, s1_hll_nxt;
  logic signed [64:0] s1_hlh_r, s1_hlh_nxt;
  logic [60:0]        s1_hhl_r, s1_hhl_nxt;
  logic signed [61:0] s1_hhh_r, s1_hhh_nxt;
  logic signed [64:0] s1_glo_r [3];
  logic signed [64:0] s1_glo_nxt [3];
  logic signed [61:0] s1_ghi_r [3];
  logic signed [61:0] s1_ghi_nxt [3];
  logic [63:0]        s1_ell_r, s1_ell_nxt;
  logic signed [66:0] s1_elh_r, s1_elh_nxt;
  logic [60:0]        s1_ehl_r, s1_ehl_nxt;
  logic signed [63:0] s1_ehh_r, s1_ehh_nxt;

  // stage 2
  logic signed [127:0] hsum;
  logic signed [127:0] esum;
  logic signed [95:0]  gsum [3];
  logic signed [63:0]  s2_hb_r, s2_hb_nxt;
  logic signed [63:0]  s2_gb_r [3];
  logic signed [63:0]  s2_gb_nxt [3];
  logic [32:0]         s2_en_r, s2_en_nxt;

  // stage 3
  logic signed [64:0] s3_mlo_r [3];
  logic signed [64:0] s3_mlo_nxt [3];
  logic signed [63:0] s3_mhi_r [3];
  logic signed [63:0] s3_mhi_nxt [3];
  logic signed [64:0] s3_nlo_r [3];
  logic signed [64:0] s3_nlo_nxt [3];
  logic signed [63:0] s3_nhi_r [3];
  logic signed [63:0] s3_nhi_nxt [3];
  logic [32:0]        s3_en_r;

  // stage 4
  logic signed [95:0] acc [3];
  logic [32:0]        mom_sat [3];
  lbfv_res_t          res_r, res_nxt;

  always_comb begin
    c_nxt.e   = word_i.e;
    c_nxt.p   = {word_i.pz, word_i.py, word_i.px};
    c_nxt.b   = {word_i.bz, word_i.by, word_i.bx};
    c_nxt.inv = word_i.invalid;
    s0_hq_nxt = word_i.zero ? '0 :
                word_i.gq - (61'd1 << 30) + 61'(word_i.quo[29:0]);
    s0_es_nxt = (66'(word_i.e) <<< 30) + 66'(word_i.bp);
  end

  always_comb begin
    s1_hll_nxt = 64'(s0_hq_r[31:0]) * 64'(word_bp_lo_r);
    s1_hlh_nxt = $signed({1'b0, s0_hq_r[31:0]}) * $signed(word_bp_hi_r);
    s1_hhl_nxt = 61'(s0_hq_r[60:32]) * 61'(word_bp_lo_r);
    s1_hhh_nxt = $signed({1'b0, s0_hq_r[60:32]}) * $signed(word_bp_hi_r);
    for (int i = 0; i < 3; i++) begin
      s1_glo_nxt[i] = $signed({1'b0, s0_gq_r[31:0]}) * $signed(c_r[0].b[i]);
      s1_ghi_nxt[i] = $signed({1'b0, s0_gq_r[60:32]}) * $signed(c_r[0].b[i]);
    end
    s1_ell_nxt = 64'(s0_gq_r[31:0]) * 64'(s0_es_r[31:0]);
    s1_elh_nxt = $signed({1'b0, s0_gq_r[31:0]}) * $signed(s0_es_r[65:32]);
    s1_ehl_nxt = 61'(s0_gq_r[60:32]) * 61'(s0_es_r[31:0]);
    s1_ehh_nxt = $signed({1'b0, s0_gq_r[60:32]}) * $signed(s0_es_r[65:32]);
  end

  always_comb begin
    hsum = 128'(s1_hll_r) + (128'(s1_hlh_r) << 32) + (128'(s1_hhl_r) << 32)
         + (128'(s1_hhh_r) << 64);
    esum = 128'(s1_ell_r) + (128'(s1_elh_r) << 32) + (128'(s1_ehl_r) << 32)
         + (128'(s1_ehh_r) << 64);
    s2_hb_nxt = hsum[123:60];
    for (int i = 0; i < 3; i++) begin
      gsum[i]      = 96'(s1_glo_r[i]) + (96'(s1_ghi_r[i]) << 32);
      s2_gb_nxt[i] = gsum[i][93:30];
    end
    s2_en_nxt = sat32(72'($signed(esum[127:60])));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_mlo_nxt[i] = $signed({1'b0, s2_hb_r[31:0]}) * $signed(c_r[2].b[i]);
      s3_mhi_nxt[i] = $signed(s2_hb_r[63:32]) * $signed(c_r[2].b[i]);
      s3_nlo_nxt[i] = $signed({1'b0, s2_gb_r[i][31:0]}) * $signed(c_r[2].e);
      s3_nhi_nxt[i] = $signed(s2_gb_r[i][63:32]) * $signed(c_r[2].e);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (96'($signed(c_r[3].p[i])) <<< 30) + 96'(s3_mlo_r[i])
             + (96'(s3_mhi_r[i]) << 32) + 96'(s3_nlo_r[i]) + (96'(s3_nhi_r[i]) << 32);
      mom_sat[i] = sat32(72'($signed(acc[i][95:30])));
    end
    if (c_r[3].inv) begin
      res_nxt.energy       = c_r[3].e;
      res_nxt.mom_x        = c_r[3].p[0];
      res_nxt.mom_y        = c_r[3].p[1];
      res_nxt.mom_z        = c_r[3].p[2];
      res_nxt.beta_invalid = 1'b1;
      res_nxt.overflow     = 1'b0;
    end else begin
      res_nxt.energy       = s3_en_r[31:0];
      res_nxt.mom_x        = mom_sat[0][31:0];
      res_nxt.mom_y        = mom_sat[1][31:0];
      res_nxt.mom_z        = mom_sat[2][31:0];
      res_nxt.beta_invalid = 1'b0;
      res_nxt.overflow     = s3_en_r[32] | mom_sat[0][32] | mom_sat[1][32] | mom_sat[2][32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]       <= c_nxt;
      c_r[1]       <= c_r[0];
      c_r[2]       <= c_r[1];
      c_r[3]       <= c_r[2];
      s0_hq_r      <= s0_hq_nxt;
      s0_gq_r      <= word_i.gq;
      s0_es_r      <= s0_es_nxt;
      word_bp_lo_r <= word_i.bp[31:0];
      word_bp_hi_r <= word_i.bp[63:32];
      s1_hll_r     <= s1_hll_nxt;
      s1_hlh_r     <= s1_hlh_nxt;
      s1_hhl_r     <= s1_hhl_nxt;
      s1_hhh_r     <= s1_hhh_nxt;
      s1_ell_r     <= s1_ell_nxt;
      s1_elh_r     <= s1_elh_nxt;
      s1_ehl_r     <= s1_ehl_nxt;
      s1_ehh_r     <= s1_ehh_nxt;
      s2_hb_r      <= s2_hb_nxt;
      s2_en_r      <= s2_en_nxt;
      s3_en_r      <= s2_en_r;
      res_r        <= res_nxt;
      for (int i = 0; i < 3; i++) begin
        s1_glo_r[i] <= s1_glo_nxt[i];
        s1_ghi_r[i] <= s1_ghi_nxt[i];
        s2_gb_r[i]  <= s2_gb_nxt[i];
        s3_mlo_r[i] <= s3_mlo_nxt[i];
        s3_mhi_r[i] <= s3_mhi_nxt[i];
        s3_nlo_r[i] <= s3_nlo_nxt[i];
        s3_nhi_r[i] <= s3_nhi_nxt[i];
      end
    end
  end

  assign valid_o = vld_r[4];
  assign res_o   = res_r;

endmodule

`default_nettype wire

>>> rtl/core/lorentz_boost_four_vector.sv
// lorentz_boost_four_vector: general lorentz boost of one four-momentum
// depends on lbfv_pkg, lbfv_ifs, lbfv_norm_cell, lbfv_root_cell, lbfv_div_cell, lbfv_tail
//
//   channel  direction  payload
//   in_ch    sink       energy_in, mom_x_in/y/z, beta_x/y/z
//   out_ch   source     energy_out, mom_x_out/y/z, beta_invalid, overflow
//
// one transaction per cycle in, one per cycle out, while the output is not stalled
// the chain is made of these stages: 2 front stages, 5 normalize, 31 square root,
// 61 gamma divide, 30 divide for (gamma-1)/beta^2, 5 multiply stages, 1 output
// synchronous active-low reset clears all valid bits
// a result waiting at the output does not stop the chain until the next result reaches the tail's last stage
`default_nettype none

module lorentz_boost_four_vector (
  input  logic clk,
  input  logic rst_n,
  lbfv_in_if.sink    in_ch,
  lbfv_out_if.source out_ch
);
  import lbfv_pkg::*;

  logic en;

  // front stage 0: squares and momentum-velocity products
  logic               f0_valid_r;
  logic signed [31:0] in_p [4];
  logic signed [31:0] in_b [3];
  logic [31:0]        mag [3];
  logic signed [31:0] f0_p_r [4];
  logic signed [31:0] f0_b_r [3];
  logic [63:0]        f0_sq_r [3];
  logic [63:0]        f0_sq_nxt [3];
  logic signed [63:0] f0_pb_r [3];
  logic signed [63:0] f0_pb_nxt [3];

  // front stage 1: beta^2, b.p, radicand
  logic [63:0]  b2;
  logic         w_valid_r;
  lbfv_word_t   w_r;
  lbfv_word_t   w_nxt;

  logic         nv [NORM_CELLS + 1];
  lbfv_word_t   nw [NORM_CELLS + 1];
  logic         rv [ROOT_CELLS + 1];
  lbfv_word_t   rw [ROOT_CELLS + 1];
  logic         qv [QUO1_CELLS + 1];
  lbfv_word_t   qw [QUO1_CELLS + 1];
  logic         hv [QUO2_CELLS + 1];
  lbfv_word_t   hw [QUO2_CELLS + 1];

  logic         tail_valid;
  lbfv_res_t    tail_res;
  logic         out_valid_r, out_valid_nxt;
  lbfv_res_t    out_res_r, out_res_nxt;

  assign en          = !(tail_valid && out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;

  always_comb begin
    in_p[0] = in_ch.energy_in;
    in_p[1] = in_ch.mom_x_in;
    in_p[2] = in_ch.mom_y_in;
    in_p[3] = in_ch.mom_z_in;
    in_b[0] = in_ch.beta_x;
    in_b[1] = in_ch.beta_y;
    in_b[2] = in_ch.beta_z;
    for (int i = 0; i < 3; i++) begin
      mag[i]       = in_b[i][31] ? 32'(-in_b[i]) : 32'(in_b[i]);
      f0_sq_nxt[i] = 64'(mag[i]) * 64'(mag[i]);
      f0_pb_nxt[i] = in_p[i + 1] * in_b[i];
    end
  end

  always_comb begin
    b2 = f0_sq_r[0] + f0_sq_r[1] + f0_sq_r[2];
    w_nxt         = '0;
    w_nxt.e       = f0_p_r[0];
    w_nxt.px      = f0_p_r[1];
    w_nxt.py      = f0_p_r[2];
    w_nxt.pz      = f0_p_r[3];
    w_nxt.bx      = f0_b_r[0];
    w_nxt.by      = f0_b_r[1];
    w_nxt.bz      = f0_b_r[2];
    w_nxt.bp      = f0_pb_r[0] + f0_pb_r[1] + f0_pb_r[2];
    w_nxt.invalid = |b2[63:60];
    w_nxt.zero    = b2 == '0;
    w_nxt.rad     = (61'd1 << 60) - 61'(b2[59:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r <= 1'b0;
      w_valid_r  <= 1'b0;
    end else if (en) begin
      f0_valid_r <= in_ch.valid;
      w_valid_r  <= f0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
      for (int i = 0; i < 4; i++) begin
        f0_p_r[i] <= in_p[i];
      end
      for (int i = 0; i < 3; i++) begin
        f0_b_r[i]  <= in_b[i];
        f0_sq_r[i] <= f0_sq_nxt[i];
        f0_pb_r[i] <= f0_pb_nxt[i];
      end
    end
  end

  assign nv[0] = w_valid_r;
  assign nw[0] = w_r;

  for (genvar i = 0; i < NORM_CELLS; i++) begin : g_norm
    lbfv_norm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .step_i  (3'(i)),
      .valid_i (nv[i]),
      .word_i  (nw[i]),
      .valid_o (nv[i + 1]),
      .word_o  (nw[i + 1])
    );
  end

  assign rv[0] = nv[NORM_CELLS];
  assign rw[0] = nw[NORM_CELLS];

  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
    lbfv_root_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .iter_i  (5'(i)),
      .valid_i (rv[i]),
      .word_i  (rw[i]),
      .valid_o (rv[i + 1]),
      .word_o  (rw[i + 1])
    );
  end

  // gamma = 2^(60+k) / root, first partial remainder is 2^k
  always_comb begin
    qv[0]     = rv[ROOT_CELLS];
    qw[0]     = rw[ROOT_CELLS];
    qw[0].rem = 63'd1 << rw[ROOT_CELLS].k;
    qw[0].dvs = 62'(rw[ROOT_CELLS].root[30:0]);
    qw[0].quo = '0;
  end

  for (genvar i = 0; i < QUO1_CELLS; i++) begin : g_quo1
    lbfv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (qv[i]),
      .word_i  (qw[i]),
      .valid_o (qv[i + 1]),
      .word_o  (qw[i + 1])
    );
  end

  // 2^60 / (gamma + 1), first partial remainder is 2^31
  always_comb begin
    hv[0]     = qv[QUO1_CELLS];
    hw[0]     = qw[QUO1_CELLS];
    hw[0].gq  = qw[QUO1_CELLS].quo;
    hw[0].dvs = 62'(qw[QUO1_CELLS].quo) + (62'd1 << 30);
    hw[0].rem = 63'd1 << 31;
  end

  for (genvar i = 0; i < QUO2_CELLS; i++) begin : g_quo2
    lbfv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (hv[i]),
      .word_i  (hw[i]),
      .valid_o (hv[i + 1]),
      .word_o  (hw[i + 1])
    );
  end

  lbfv_tail u_tail (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (hv[QUO2_CELLS]),
    .word_i  (hw[QUO2_CELLS]),
    .valid_o (tail_valid),
    .res_o   (tail_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (tail_valid && en) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = tail_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.energy_out   = out_res_r.energy;
  assign out_ch.mom_x_out    = out_res_r.mom_x;
  assign out_ch.mom_y_out    = out_res_r.mom_y;
  assign out_ch.mom_z_out    = out_res_r.mom_z;
  assign out_ch.beta_invalid = out_res_r.beta_invalid;
  assign out_ch.overflow     = out_res_r.overflow;

  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.beta_invalid |-> !out_res_r.overflow)
    else $error("overflow flagged on a passed-through transaction");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the chain end is blocked");

  a_reset_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid && out_valid_r && !out_ch.ready |=> tail_valid && out_valid_r)
    else $error("waiting result lost during stall");

endmodule

`default_nettype wire
